// ===== src/rdc_pkg.sv =====
`timescale 1ns / 1ps

package rdc_pkg;

  // Field widths of the item and result channels.
  localparam int VALUE_W = 31;
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;

  // Size of the digit buffer and the counters that address it.
  localparam int MAX_DIGITS = 31;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  // The divider retires this many quotient bits per clock.
  localparam int BITS_PER_CYC = 4;
  localparam int DIV_W        = ((VALUE_W + BITS_PER_CYC - 1) / BITS_PER_CYC) * BITS_PER_CYC;
  localparam int DIV_CYCLES   = DIV_W / BITS_PER_CYC;
  localparam int STEP_W       = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Radix limits and ASCII anchors.
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_NINE = CHAR_W'(57);
  localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(65);
  localparam logic [CHAR_W-1:0]  CHAR_F    = CHAR_W'(70);
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = DIGIT_W'(10);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             start;
    logic             div_step;
    logic             div_first;
    logic             wr_digit;
    logic [IDX_W-1:0] wr_idx;
    logic             load_out;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_last;
  } rdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_zero;
  } rdc_stat_t;

  // Force the radix into the supported range.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Map a digit to its ASCII character.
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_LIMIT) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    end
    return res;
  endfunction

endpackage

// ===== src/rdc_datapath.sv =====
`timescale 1ns / 1ps

module rdc_datapath
  import rdc_pkg::*;
(
  input  logic               clk,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [RADIX_W-1:0] in_radix,
  input  rdc_cmd_t           cmd,
  output rdc_stat_t          stat,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit
);

  logic [DIV_W-1:0]   q_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [RADIX_W-1:0] radix_r;
  logic [DIV_W-1:0]   q_nxt;
  logic [DIGIT_W-1:0] rem_nxt;
  logic [DIGIT_W-1:0] digit_store_r [MAX_DIGITS];
  logic [CHAR_W-1:0]  out_digit_char_r;
  logic               out_last_digit_r;

  // Restoring division, several quotient bits per clock.
  always_comb begin
    logic [DIGIT_W-1:0] rem_v;
    logic [DIV_W-1:0]   q_v;
    logic [DIGIT_W:0]   t_v;
    rem_v = cmd.div_first ? '0 : rem_r;
    q_v   = q_r;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      t_v = {rem_v, q_v[DIV_W-1]};
      q_v = {q_v[DIV_W-2:0], 1'b0};
      if (t_v >= (DIGIT_W+1)'(radix_r)) begin
        t_v    = t_v - (DIGIT_W+1)'(radix_r);
        q_v[0] = 1'b1;
      end
      rem_v = t_v[DIGIT_W-1:0];
    end
    q_nxt   = q_v;
    rem_nxt = rem_v;
  end

  // Dividend, remainder and radix registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r     <= DIV_W'(in_value);
      radix_r <= clamp_radix(in_radix);
    end else if (cmd.div_step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Digit buffer: the final step of each division writes its remainder.
  always_ff @(posedge clk) begin
    if (cmd.wr_digit) begin
      digit_store_r[cmd.wr_idx] <= rem_nxt;
    end
  end

  // Registered read straight into the output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_digit_char_r <= to_ascii(digit_store_r[cmd.rd_idx]);
      out_last_digit_r <= cmd.rd_last;
    end
  end

  assign stat.q_zero    = (q_r == '0);
  assign out_digit_char = out_digit_char_r;
  assign out_last_digit = out_last_digit_r;

endmodule

// ===== src/rdc_ctrl.sv =====
`timescale 1ns / 1ps

module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rdc_stat_t stat,
  output rdc_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_CYCLES - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_DIGITS);

  logic [1:0]        state_r,     state_nxt;
  logic [STEP_W-1:0] step_r,      step_nxt;
  logic [CNT_W-1:0]  cnt_r,       cnt_nxt;
  logic [IDX_W-1:0]  idx_r,       idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  cnt_dec;

  assign cnt_dec = cnt_r - CNT_W'(1);

  // Sequencer: divide per digit, then play the buffer back from the top.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.wr_idx    = cnt_r[IDX_W-1:0];
    cmd.rd_idx    = idx_r;
    cmd.rd_last   = (idx_r == '0);
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step_r == '0);
        if (step_r == STEP_LAST) begin
          cmd.wr_digit = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
          step_nxt     = '0;
          state_nxt    = ST_CHECK;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_CHECK: begin
        if (stat.q_zero || (cnt_r == CNT_FULL)) begin
          idx_nxt   = cnt_dec[IDX_W-1:0];
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The output register fills on a load and empties on a transfer.
  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/radix_digit_converter_core.sv =====
`timescale 1ns / 1ps

// Converts one non-negative integer per input transfer into its digits in a
// radix from 2 to 16 (other radix codes are clamped to that range) and
// returns them most significant first as ASCII '0'-'9', 'A'-'F', one digit per
// output transfer, with out_last_digit on the final one. Zero gives a single
// '0'. A restoring divider retires four quotient bits per clock, so each
// digit takes a full division followed by a check, and the digits then
// leave at one per cycle while the output is not stalled, from a registered
// digit buffer. The next item is taken as soon as the final digit sits in
// the output register.
module radix_digit_converter_core
  import rdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [RADIX_W-1:0] in_radix,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit
);

  rdc_cmd_t  cmd;
  rdc_stat_t stat;

  // Sequencer.
  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Divider, digit buffer and output register.
  rdc_datapath u_dp (
    .clk            (clk),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .cmd            (cmd),
    .stat           (stat),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

// ===== src/rdc_checker.sv =====
`timescale 1ns / 1ps

module rdc_checker
  import rdc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CHAR_W-1:0]  out_digit_char,
  input logic               out_last_digit
);

  // A stalled result holds its digit and flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char) && $stable(out_last_digit))
    else $error("output changed while stalled");

  // Every character shown is a legal digit character.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_char >= CHAR_ZERO) && (out_digit_char <= CHAR_NINE)) ||
                  ((out_digit_char >= CHAR_A) && (out_digit_char <= CHAR_F)))
    else $error("illegal digit character");

  // After taking an item the block is busy dividing.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  // While the block is free, a waiting result can only be a final digit.
  a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last_digit)
    else $error("non-final digit pending while idle");

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (.*);

// ===== tb/sv/tb_radix_digit_converter_core.sv =====
`timescale 1ns / 1ps

import rdc_pkg::*;

// One expected output transfer: the ASCII digit and the final-digit flag.
typedef struct {
  logic [CHAR_W-1:0] ascii;
  logic              last;
} digit_t;

// Predicts the digit string of every accepted conversion and checks the
// digits that come back, in order.
class digit_ledger;
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
  logic [CNT_W-1:0]   digit_total;
  digit_t             pending_digits[$];
  int                 mismatch_count;

  function new();
    digit_total    = '0;
    mismatch_count = 0;
  endfunction

  // Prints one line per mismatch and counts it.
  task report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Divides the value by the clamped radix repeatedly, then queues the
  // digits most significant first.
  function void note_conversion(input logic [VALUE_W-1:0] value,
                                input logic [RADIX_W-1:0] radix);
    int unsigned base;
    int unsigned rest;
    int          n;
    int          k;
    digit_t      d;
    base = radix;
    if (base < 2) begin
      base = 2;
    end else if (base > 16) begin
      base = 16;
    end
    rest = value;
    n    = 0;
    do begin
      digit_store[n] = DIGIT_W'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    digit_total = CNT_W'(n);
    for (k = n - 1; k >= 0; k--) begin
      if (digit_store[k] < 10) begin
        d.ascii = CHAR_ZERO + CHAR_W'(digit_store[k]);
      end else begin
        d.ascii = CHAR_A + CHAR_W'(digit_store[k] - 4'd10);
      end
      d.last = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  // Compares one output transfer with the oldest expected digit.
  task check_digit(input logic [CHAR_W-1:0] ascii, input logic last);
    digit_t d;
    if (pending_digits.size() == 0) begin
      report_mismatch($sformatf("unexpected digit 0x%02h last=%0b", ascii, last));
    end else begin
      d = pending_digits.pop_front();
      if (ascii !== d.ascii) begin
        report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h", ascii, d.ascii));
      end
      if (last !== d.last) begin
        report_mismatch($sformatf("last_digit %0b, expected %0b", last, d.last));
      end
    end
  endtask
endclass

module tb_radix_digit_converter_core;

  localparam int RANDOM_ITEMS = 148;
  localparam int CYCLE_LIMIT  = 600000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value;
  logic [RADIX_W-1:0] in_radix;
  logic               out_valid;
  logic               out_ready;
  logic [CHAR_W-1:0]  out_digit_char;
  logic               out_last_digit;

  digit_ledger ledger = new();
  int          burst_left;
  int          cycle_count;
  int unsigned ready_phase;

  radix_digit_converter_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check every transfer, then pick the next ready value. The
  // stall pattern steps through four phases of ready_phase: always ready,
  // random, one in three low, and mostly stalled.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      ledger.check_digit(out_digit_char, out_last_digit);
    end
    ready_phase <= ready_phase + 1;
    case ((ready_phase >> 7) % 4)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_ready <= ((ready_phase % 3) != 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Presents one conversion and holds it until the transfer happens.
  task automatic send_conversion(input logic [VALUE_W-1:0] value,
                                 input logic [RADIX_W-1:0] radix);
    in_valid <= 1'b1;
    in_value <= value;
    in_radix <= radix;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    ledger.note_conversion(value, radix);
  endtask

  // Ends a burst with a random gap, or keeps valid high inside a burst. With
  // drain set, the sender also waits until every expected digit is out.
  task automatic pause_sender(input bit drain);
    if (drain || burst_left == 0) begin
      in_valid <= 1'b0;
      if (drain) begin
        while (ledger.pending_digits.size() != 0) begin
          @(posedge clk);
        end
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(0, 7);
    end else begin
      burst_left--;
    end
  endtask

  task automatic convert(input logic [VALUE_W-1:0] value,
                         input logic [RADIX_W-1:0] radix,
                         input bit drain = 1'b0);
    send_conversion(value, radix);
    pause_sender(drain);
  endtask

  // Random value: full width, random width, small, or a run of ones.
  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return VALUE_W'($urandom);
    end else if (sel < 7) begin
      return VALUE_W'($urandom >> $urandom_range(1, 31));
    end else if (sel < 9) begin
      return VALUE_W'($urandom_range(0, 40));
    end
    return {VALUE_W{1'b1}} >> $urandom_range(0, 30);
  endfunction

  // Mostly legal radixes, sometimes any 5-bit code.
  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 6) == 0) begin
      return RADIX_W'($urandom_range(0, 31));
    end
    return RADIX_W'($urandom_range(2, 16));
  endfunction

  initial begin
    int i;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_value    <= '0;
    in_radix    <= '0;
    burst_left  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, extremes, clamped radixes, letter digits, boundaries.
    convert(31'd0, 5'd10);
    convert(31'd0, 5'd2);
    convert(31'd1, 5'd2);
    convert(31'h7FFFFFFF, 5'd2);
    convert(31'h7FFFFFFF, 5'd16);
    convert(31'h7FFFFFFF, 5'd3);
    convert(31'h7FFFFFFF, 5'd10);
    convert(31'd5, 5'd0);
    convert(31'd6, 5'd1);
    convert(31'd255, 5'd17);
    convert(31'h7FEDCBA9, 5'd31);
    convert(31'h7FEDCBA9, 5'd16);
    convert(31'd14, 5'd15);
    convert(31'd15, 5'd16);
    convert(31'd16, 5'd16);
    convert(31'd9, 5'd10);
    convert(31'd10, 5'd10);
    convert(31'd48, 5'd7);
    convert(31'h40000000, 5'd2);
    convert(31'd123456789, 5'd8);
    convert(31'h2AAAAAAA, 5'd4);
    convert(31'h55555555, 5'd11, 1'b1);

    // Random conversions, with a full drain halfway through and at the end.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      convert(pick_value(), pick_radix(), (i == RANDOM_ITEMS / 2) || (i == RANDOM_ITEMS - 1));
    end

    // Let any stray digit show up before the verdict.
    repeat (40) @(posedge clk);
    if (ledger.mismatch_count == 0 && ledger.pending_digits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rdc_pkg.sv
src/rdc_datapath.sv
src/rdc_ctrl.sv
src/radix_digit_converter_core.sv
src/rdc_checker.sv
tb/sv/tb_radix_digit_converter_core.sv
